>>> hw/rtl/bpc_pkg.sv
package bpc_pkg;

	typedef logic signed [23:0] raw_t;
	typedef logic signed [32:0] scaled_t;
	typedef logic [47:0] cfg_data_t;
	typedef logic [2:0] cfg_index_t;

	typedef enum logic [2:0] {
		REG_TEMP_COEF = 3'd0,
		REG_PRES_OFFS = 3'd1,
		REG_CROSS     = 3'd2,
		REG_HIGHER    = 3'd3,
		REG_PRES_OSR  = 3'd4,
		REG_TEMP_OSR  = 3'd5
	} cfg_reg_t;

	localparam logic [2:0] PRES_OSR_RESET = 3'd4;
	localparam logic [2:0] TEMP_OSR_RESET = 3'd0;

	// round(2^50 / scale factor) for oversampling codes 1x..128x
	localparam logic [32:0] RECIP_TBL [8] = '{
		33'd2147483648, 33'd715827883, 33'd306783378, 33'd143165577,
		33'd4433514628, 33'd2181570690, 33'd1082196484, 33'd538976288
	};

	typedef struct packed {
		logic [11:0] c0;
		logic [11:0] c1;
		logic [19:0] c00;
		logic [19:0] c10;
		logic [15:0] c01;
		logic [15:0] c11;
		logic [15:0] c20;
		logic [15:0] c21;
		logic [15:0] c30;
		logic [2:0]  pres_osr;
		logic [2:0]  temp_osr;
	} coef_t;

endpackage

>>> hw/rtl/bpc_cfg.sv
module bpc_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  bpc_pkg::cfg_index_t  cfg_index,
	input  bpc_pkg::cfg_data_t   cfg_data,
	output bpc_pkg::coef_t       coef
);

	logic [23:0] temp_coef_q;
	logic [39:0] pres_offs_q;
	logic [31:0] cross_q;
	logic [47:0] higher_q;
	logic [2:0]  pres_osr_q;
	logic [2:0]  temp_osr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q <= '0;
			pres_offs_q <= '0;
			cross_q     <= '0;
			higher_q    <= '0;
			pres_osr_q  <= bpc_pkg::PRES_OSR_RESET;
			temp_osr_q  <= bpc_pkg::TEMP_OSR_RESET;
		end else if (cfg_valid) begin
			case (bpc_pkg::cfg_reg_t'(cfg_index))
				bpc_pkg::REG_TEMP_COEF: temp_coef_q <= cfg_data[23:0];
				bpc_pkg::REG_PRES_OFFS: pres_offs_q <= cfg_data[39:0];
				bpc_pkg::REG_CROSS:     cross_q     <= cfg_data[31:0];
				bpc_pkg::REG_HIGHER:    higher_q    <= cfg_data[47:0];
				bpc_pkg::REG_PRES_OSR:  pres_osr_q  <= cfg_data[2:0];
				bpc_pkg::REG_TEMP_OSR:  temp_osr_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.c0       = temp_coef_q[23:12];
		coef.c1       = temp_coef_q[11:0];
		coef.c00      = pres_offs_q[39:20];
		coef.c10      = pres_offs_q[19:0];
		coef.c01      = cross_q[31:16];
		coef.c11      = cross_q[15:0];
		coef.c20      = higher_q[47:32];
		coef.c21      = higher_q[31:16];
		coef.c30      = higher_q[15:0];
		coef.pres_osr = pres_osr_q;
		coef.temp_osr = temp_osr_q;
	end

endmodule

>>> hw/rtl/bpc_scale.sv
module bpc_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  bpc_pkg::raw_t     pres_raw,
	input  bpc_pkg::raw_t     temp_raw,
	input  bpc_pkg::coef_t    coef,
	output logic              dn_valid,
	input  logic              dn_ready,
	output bpc_pkg::scaled_t  p,
	output bpc_pkg::scaled_t  t
);

	logic               v_s1, v_s2;
	logic               en1, en2;
	logic signed [33:0] prec, trec;
	logic signed [57:0] pprod, tprod;
	logic signed [57:0] pprod_s1, tprod_s1;
	logic signed [57:0] pround, tround;
	bpc_pkg::scaled_t   p_s2, t_s2;

	assign en2      = !v_s2 || dn_ready;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	assign prec  = $signed({1'b0, bpc_pkg::RECIP_TBL[coef.pres_osr]});
	assign trec  = $signed({1'b0, bpc_pkg::RECIP_TBL[coef.temp_osr]});
	assign pprod = pres_raw * prec;
	assign tprod = temp_raw * trec;

	assign pround = pprod_s1 + 58'sd8388608;
	assign tround = tprod_s1 + 58'sd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			pprod_s1 <= pprod;
			tprod_s1 <= tprod;
		end
		if (en2 && v_s1) begin
			p_s2 <= pround[56:24];
			t_s2 <= tround[56:24];
		end
	end

	assign dn_valid = v_s2;
	assign p        = p_s2;
	assign t        = t_s2;

endmodule

>>> hw/rtl/bpc_poly.sv
module bpc_poly (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  bpc_pkg::scaled_t   p,
	input  bpc_pkg::scaled_t   t,
	input  bpc_pkg::coef_t     coef,
	output logic               dn_valid,
	input  logic               dn_ready,
	output logic signed [48:0] base,
	output logic signed [57:0] lin,
	output logic signed [57:0] qua3,
	output logic [15:0]        temp
);

	logic v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en3, en4, en5, en6, en7, en8;

	// stage 3: coefficient products
	bpc_pkg::scaled_t   p_s3, t_s3;
	logic signed [48:0] c30p_s3, c21p_s3, c01t_s3;
	logic signed [44:0] c1t_s3;

	// stage 4: first-order sums
	bpc_pkg::scaled_t   p_s4, t_s4;
	logic signed [48:0] inner_s4, inner3_s4, base_s4;
	logic signed [44:0] tq_s4;

	// stage 5: split products with p
	bpc_pkg::scaled_t   p_s5, t_s5;
	logic signed [55:0] pih_s5, p3h_s5;
	logic signed [59:0] pil_s5, p3l_s5;
	logic signed [48:0] base_s5;
	logic [15:0]        temp_s5;
	logic signed [44:0] tround;
	logic [26:0]        tshift;

	// stage 6: recombine
	bpc_pkg::scaled_t   p_s6, t_s6;
	logic signed [52:0] qua2_s6, x_s6;
	logic signed [48:0] base_s6;
	logic [15:0]        temp_s6;
	logic signed [59:0] pil_r, p3l_r;
	logic signed [55:0] qua2_sum, x_sum;

	// stage 7: split products of second level
	logic signed [59:0] lh_s7, ll_s7, qh_s7, ql_s7;
	logic signed [48:0] base_s7;
	logic [15:0]        temp_s7;

	// stage 8: recombine
	logic signed [57:0] lin_s8, qua3_s8;
	logic signed [48:0] base_s8;
	logic [15:0]        temp_s8;
	logic signed [59:0] ll_r, ql_r, lin_sum, qua3_sum;

	assign en8      = !v_s8 || dn_ready;
	assign en7      = !v_s7 || en8;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign up_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en3) v_s3 <= up_valid;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	assign tround = tq_s4 + 45'sd131072;
	assign tshift = tround[44:18];

	assign pil_r    = pil_s5 + 60'sd33554432;
	assign p3l_r    = p3l_s5 + 60'sd33554432;
	assign qua2_sum = $signed({{10{coef.c10[19]}}, coef.c10, 26'd0}) + pih_s5
		+ $signed({{22{pil_r[59]}}, pil_r[59:26]});
	assign x_sum    = p3h_s5 + $signed({{22{p3l_r[59]}}, p3l_r[59:26]});

	assign ll_r     = ll_s7 + 60'sd33554432;
	assign ql_r     = ql_s7 + 60'sd33554432;
	assign lin_sum  = lh_s7 + $signed({{26{ll_r[59]}}, ll_r[59:26]});
	assign qua3_sum = qh_s7 + $signed({{26{ql_r[59]}}, ql_r[59:26]});

	always_ff @(posedge clk) begin
		if (en3 && up_valid) begin
			p_s3    <= p;
			t_s3    <= t;
			c30p_s3 <= $signed(coef.c30) * p;
			c21p_s3 <= $signed(coef.c21) * p;
			c01t_s3 <= $signed(coef.c01) * t;
			c1t_s3  <= $signed(coef.c1) * t;
		end
		if (en4 && v_s3) begin
			p_s4      <= p_s3;
			t_s4      <= t_s3;
			inner_s4  <= $signed({{7{coef.c20[15]}}, coef.c20, 26'd0}) + c30p_s3;
			inner3_s4 <= $signed({{7{coef.c11[15]}}, coef.c11, 26'd0}) + c21p_s3;
			base_s4   <= $signed({{3{coef.c00[19]}}, coef.c00, 26'd0}) + c01t_s3;
			tq_s4     <= $signed({{8{coef.c0[11]}}, coef.c0, 25'd0}) + c1t_s3;
		end
		if (en5 && v_s4) begin
			p_s5    <= p_s4;
			t_s5    <= t_s4;
			pih_s5  <= p_s4 * $signed(inner_s4[48:26]);
			pil_s5  <= p_s4 * $signed({1'b0, inner_s4[25:0]});
			p3h_s5  <= p_s4 * $signed(inner3_s4[48:26]);
			p3l_s5  <= p_s4 * $signed({1'b0, inner3_s4[25:0]});
			base_s5 <= base_s4;
			if (tshift[26:15] == {12{tshift[26]}}) begin
				temp_s5 <= tshift[15:0];
			end else begin
				temp_s5 <= tshift[26] ? 16'h8000 : 16'h7fff;
			end
		end
		if (en6 && v_s5) begin
			p_s6    <= p_s5;
			t_s6    <= t_s5;
			qua2_s6 <= qua2_sum[52:0];
			x_s6    <= x_sum[52:0];
			base_s6 <= base_s5;
			temp_s6 <= temp_s5;
		end
		if (en7 && v_s6) begin
			lh_s7   <= p_s6 * $signed(qua2_s6[52:26]);
			ll_s7   <= p_s6 * $signed({1'b0, qua2_s6[25:0]});
			qh_s7   <= t_s6 * $signed(x_s6[52:26]);
			ql_s7   <= t_s6 * $signed({1'b0, x_s6[25:0]});
			base_s7 <= base_s6;
			temp_s7 <= temp_s6;
		end
		if (en8 && v_s7) begin
			lin_s8  <= lin_sum[57:0];
			qua3_s8 <= qua3_sum[57:0];
			base_s8 <= base_s7;
			temp_s8 <= temp_s7;
		end
	end

	assign dn_valid = v_s8;
	assign base     = base_s8;
	assign lin      = lin_s8;
	assign qua3     = qua3_s8;
	assign temp     = temp_s8;

endmodule

>>> hw/rtl/bpc_out.sv
module bpc_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic signed [48:0] base,
	input  logic signed [57:0] lin,
	input  logic signed [57:0] qua3,
	input  logic [15:0]        temp,
	output logic               dn_valid,
	input  logic               dn_ready,
	output logic signed [31:0] pres_fixed,
	output logic signed [15:0] temp_fixed
);

	logic               v_s9, v_s10;
	logic               en9, en10;
	logic signed [58:0] sum_s9;
	logic [15:0]        temp_s9;
	logic signed [58:0] pround;
	logic [36:0]        pshift;
	logic [31:0]        pres_s10;
	logic [15:0]        temp_s10;

	assign en10     = !v_s10 || dn_ready;
	assign en9      = !v_s9 || en10;
	assign up_ready = en9;

	assign pround = sum_s9 + 59'sd2097152;
	assign pshift = pround[58:22];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en9) v_s9 <= up_valid;
			if (en10) v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en9 && up_valid) begin
			sum_s9 <= $signed({{10{base[48]}}, base}) + $signed({lin[57], lin})
				+ $signed({qua3[57], qua3});
			temp_s9 <= temp;
		end
		if (en10 && v_s9) begin
			if (pshift[36:31] == {6{pshift[36]}}) begin
				pres_s10 <= pshift[31:0];
			end else begin
				pres_s10 <= pshift[36] ? 32'h8000_0000 : 32'h7fff_ffff;
			end
			temp_s10 <= temp_s9;
		end
	end

	assign dn_valid   = v_s10;
	assign pres_fixed = $signed(pres_s10);
	assign temp_fixed = $signed(temp_s10);

endmodule

>>> hw/rtl/barometer_pressure_compensation_unit.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | pressure_sample, temperature_sample
// out     | output    | out_valid / out_ready | pressure_fixed, temperature_fixed
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Ten register stages from an accepted word to out_valid; one word per cycle unless stalled.
// The multipliers set the stage cut: one layer of products per stage, none wider than 34x27.
// Each stage holds or advances on its own; in_ready drops only when all are full.
// Reset clears the valid bits and loads the register reset values; cfg_ready is always high.
module barometer_pressure_compensation_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [23:0]   pressure_sample,
	input  logic signed [23:0]   temperature_sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   pressure_fixed,
	output logic signed [15:0]   temperature_fixed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  bpc_pkg::cfg_index_t  cfg_index,
	input  bpc_pkg::cfg_data_t   cfg_data
);

	bpc_pkg::coef_t     coef;
	logic               sc_valid, sc_ready;
	bpc_pkg::scaled_t   p, t;
	logic               po_valid, po_ready;
	logic signed [48:0] base;
	logic signed [57:0] lin, qua3;
	logic [15:0]        temp;

	assign cfg_ready = 1'b1;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bpc_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.pres_raw (pressure_sample),
		.temp_raw (temperature_sample),
		.coef     (coef),
		.dn_valid (sc_valid),
		.dn_ready (sc_ready),
		.p        (p),
		.t        (t)
	);

	bpc_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sc_valid),
		.up_ready (sc_ready),
		.p        (p),
		.t        (t),
		.coef     (coef),
		.dn_valid (po_valid),
		.dn_ready (po_ready),
		.base     (base),
		.lin      (lin),
		.qua3     (qua3),
		.temp     (temp)
	);

	bpc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (po_valid),
		.up_ready   (po_ready),
		.base       (base),
		.lin        (lin),
		.qua3       (qua3),
		.temp       (temp),
		.dn_valid   (out_valid),
		.dn_ready   (out_ready),
		.pres_fixed (pressure_fixed),
		.temp_fixed (temperature_fixed)
	);

endmodule

>>> hw/rtl/bpc_checker.sv
module bpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [31:0]  pressure_fixed,
	input logic signed [15:0]  temperature_fixed
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pressure_fixed) && $stable(temperature_fixed))
		else $error("output word changed while stalled");

	// input side stalls only behind a blocked output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a blocked output");

	// no word straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("out_valid high right after reset");

endmodule

bind barometer_pressure_compensation_unit bpc_checker u_bpc_checker (.*);

>>> tb/bpc_result_checker.sv
`timescale 1ns / 1ps
module bpc_result_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [23:0]   pressure_sample,
	input  logic signed [23:0]   temperature_sample,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [31:0]   pressure_fixed,
	input  logic signed [15:0]   temperature_fixed,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  bpc_pkg::cfg_index_t  cfg_index,
	input  bpc_pkg::cfg_data_t   cfg_data,
	output int                   mismatches,
	output int                   readings_due
);

	typedef struct packed {
		logic signed [31:0] pressure;
		logic signed [15:0] temperature;
	} reading_t;

	localparam longint Q_ONE = 64'sd1 <<< 26;
	localparam longint PRES_MAX = 64'sd2147483647;
	localparam longint PRES_MIN = -64'sd2147483648;
	localparam longint TEMP_MAX = 64'sd32767;
	localparam longint TEMP_MIN = -64'sd32768;
	localparam longint OSR_FACTOR [8] = '{
		64'sd524288, 64'sd1572864, 64'sd3670016, 64'sd7864320,
		64'sd253952, 64'sd516096, 64'sd1040384, 64'sd2088960
	};

	logic [23:0] temp_coefs = '0;
	logic [39:0] offset_coefs = '0;
	logic [31:0] cross_coefs = '0;
	logic [47:0] higher_coefs = '0;
	logic [2:0]  pres_osr = bpc_pkg::PRES_OSR_RESET;
	logic [2:0]  temp_osr = bpc_pkg::TEMP_OSR_RESET;

	reading_t readings_q[$];
	int mismatch_count = 0;
	int due_count = 0;

	assign mismatches = mismatch_count;
	assign readings_due = due_count;

	function automatic longint osr_recip(logic [2:0] code);
		return ((64'sd1 <<< 50) + OSR_FACTOR[code] / 2) / OSR_FACTOR[code];
	endfunction

	function automatic longint scale_q26(logic [23:0] raw, logic [2:0] code);
		longint r;
		r = longint'($signed(raw));
		return (r * osr_recip(code) + (64'sd1 <<< 23)) >>> 24;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint bh;
		longint bl;
		bh = b >>> 26;
		bl = b - (bh <<< 26);
		return a * bh + ((a * bl + (64'sd1 <<< 25)) >>> 26);
	endfunction

	function automatic reading_t compensate(logic [23:0] p_raw, logic [23:0] t_raw);
		longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
		longint p, t, temp_q, inner, quad, lin, inner3, cross_term, pres_q, pres, temp;
		reading_t r;
		c0 = longint'($signed(temp_coefs[23:12]));
		c1 = longint'($signed(temp_coefs[11:0]));
		c00 = longint'($signed(offset_coefs[39:20]));
		c10 = longint'($signed(offset_coefs[19:0]));
		c01 = longint'($signed(cross_coefs[31:16]));
		c11 = longint'($signed(cross_coefs[15:0]));
		c20 = longint'($signed(higher_coefs[47:32]));
		c21 = longint'($signed(higher_coefs[31:16]));
		c30 = longint'($signed(higher_coefs[15:0]));
		p = scale_q26(p_raw, pres_osr);
		t = scale_q26(t_raw, temp_osr);
		temp_q = c0 * (Q_ONE / 2) + c1 * t;
		inner = c20 * Q_ONE + c30 * p;
		quad = c10 * Q_ONE + qmul(p, inner);
		lin = qmul(p, quad);
		inner3 = c11 * Q_ONE + c21 * p;
		cross_term = qmul(t, qmul(p, inner3));
		pres_q = c00 * Q_ONE + lin + c01 * t + cross_term;
		pres = (pres_q + (64'sd1 <<< 21)) >>> 22;
		temp = (temp_q + (64'sd1 <<< 17)) >>> 18;
		if (pres > PRES_MAX) begin
			pres = PRES_MAX;
		end else if (pres < PRES_MIN) begin
			pres = PRES_MIN;
		end
		if (temp > TEMP_MAX) begin
			temp = TEMP_MAX;
		end else if (temp < TEMP_MIN) begin
			temp = TEMP_MIN;
		end
		r.pressure = pres[31:0];
		r.temperature = temp[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			temp_coefs = '0;
			offset_coefs = '0;
			cross_coefs = '0;
			higher_coefs = '0;
			pres_osr = bpc_pkg::PRES_OSR_RESET;
			temp_osr = bpc_pkg::TEMP_OSR_RESET;
			readings_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				readings_q.push_back(compensate(pressure_sample, temperature_sample));
			end
			if (out_valid && out_ready) begin
				if (readings_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected word pressure %0d temperature %0d",
						$time, pressure_fixed, temperature_fixed);
				end else begin
					want = readings_q.pop_front();
					if (want.pressure !== pressure_fixed) begin
						mismatch_count++;
						$display("%0t: pressure_fixed expected %0d actual %0d",
							$time, want.pressure, pressure_fixed);
					end
					if (want.temperature !== temperature_fixed) begin
						mismatch_count++;
						$display("%0t: temperature_fixed expected %0d actual %0d",
							$time, want.temperature, temperature_fixed);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bpc_pkg::REG_TEMP_COEF: temp_coefs = cfg_data[23:0];
					bpc_pkg::REG_PRES_OFFS: offset_coefs = cfg_data[39:0];
					bpc_pkg::REG_CROSS:     cross_coefs = cfg_data[31:0];
					bpc_pkg::REG_HIGHER:    higher_coefs = cfg_data[47:0];
					bpc_pkg::REG_PRES_OSR:  pres_osr = cfg_data[2:0];
					bpc_pkg::REG_TEMP_OSR:  temp_osr = cfg_data[2:0];
					default: ;
				endcase
			end
		end
		due_count = readings_q.size();
	end

endmodule

>>> tb/tb_barometer_pressure_compensation_unit.sv
`timescale 1ns / 1ps
module tb_barometer_pressure_compensation_unit;

	localparam int ITEM_TARGET = 550;
	localparam int QUIET_TAIL = 80;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int LONG_HOLD_PHASE = 4;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 300000;

	localparam bpc_pkg::cfg_index_t SPARE_INDEX_LO = 3'd6;
	localparam bpc_pkg::cfg_index_t SPARE_INDEX_HI = 3'd7;

	localparam logic [2:0] OSR_1X = 3'd0;
	localparam logic [2:0] OSR_8X = 3'd3;
	localparam logic [2:0] OSR_16X = 3'd4;
	localparam logic [2:0] OSR_128X = 3'd7;

	localparam bpc_pkg::raw_t RAW_MAX = bpc_pkg::raw_t'(24'h7FFFFF);
	localparam bpc_pkg::raw_t RAW_MIN = bpc_pkg::raw_t'(24'h800000);
	localparam bpc_pkg::raw_t EXTREME_P [5] = '{RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN,
		bpc_pkg::raw_t'(0)};
	localparam bpc_pkg::raw_t EXTREME_T [5] = '{RAW_MAX, RAW_MIN, RAW_MIN, RAW_MAX,
		bpc_pkg::raw_t'(0)};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bpc_pkg::raw_t pressure_sample = '0;
	bpc_pkg::raw_t temperature_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pressure_fixed;
	logic signed [15:0] temperature_fixed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	bpc_pkg::cfg_index_t cfg_index = '0;
	bpc_pkg::cfg_data_t cfg_data = '0;

	int mismatches;
	int readings_due;
	int cycle_count = 0;
	int items_sent = 0;
	bit long_hold = 1'b0;
	bit rx_quiet = 1'b0;
	bit tx_idles = 1'b0;

	always #10 clk = ~clk;

	barometer_pressure_compensation_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pressure_sample   (pressure_sample),
		.temperature_sample(temperature_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pressure_fixed    (pressure_fixed),
		.temperature_fixed (temperature_fixed),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	bpc_result_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pressure_sample   (pressure_sample),
		.temperature_sample(temperature_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pressure_fixed    (pressure_fixed),
		.temperature_fixed (temperature_fixed),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.readings_due      (readings_due)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_barometer_pressure_compensation_unit: errors");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				// hold the output off long enough to back up the whole pipeline
				out_ready = 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
				long_hold = 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic offer_sample(bpc_pkg::raw_t p, bpc_pkg::raw_t t);
		@(negedge clk);
		in_valid = 1'b1;
		pressure_sample = p;
		temperature_sample = t;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic sender_gap(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (readings_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_register(bpc_pkg::cfg_index_t idx, bpc_pkg::cfg_data_t value);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_all(logic [23:0] tc, logic [39:0] po, logic [31:0] cr,
			logic [47:0] hi, logic [2:0] p_osr, logic [2:0] t_osr);
		load_register(bpc_pkg::REG_TEMP_COEF, bpc_pkg::cfg_data_t'(tc));
		load_register(bpc_pkg::REG_PRES_OFFS, bpc_pkg::cfg_data_t'(po));
		load_register(bpc_pkg::REG_CROSS, bpc_pkg::cfg_data_t'(cr));
		load_register(bpc_pkg::REG_HIGHER, bpc_pkg::cfg_data_t'(hi));
		load_register(bpc_pkg::REG_PRES_OSR, bpc_pkg::cfg_data_t'(p_osr));
		load_register(bpc_pkg::REG_TEMP_OSR, bpc_pkg::cfg_data_t'(t_osr));
	endtask

	task automatic offer_extremes();
		for (int i = 0; i < 5; i++) begin
			offer_sample(EXTREME_P[i], EXTREME_T[i]);
		end
	endtask

	function automatic logic [19:0] coef_field(int bits);
		int half;
		half = 1 << (bits - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 20'(half - 1);
			2: return 20'(-half);
			3, 4: return 20'($urandom_range(0, 510) - 255);
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic bpc_pkg::raw_t pick_raw();
		case ($urandom_range(0, 7))
			0: return RAW_MAX;
			1: return RAW_MIN;
			2, 3: return bpc_pkg::raw_t'($urandom_range(0, 8190) - 4095);
			default: return bpc_pkg::raw_t'($urandom);
		endcase
	endfunction

	function automatic bpc_pkg::cfg_data_t random_data();
		return bpc_pkg::cfg_data_t'({$urandom, $urandom});
	endfunction

	task automatic configure_random();
		bpc_pkg::cfg_data_t d;
		logic [19:0] a, b, c;
		if ($urandom_range(0, 4) != 0) begin
			d = random_data();
			a = coef_field(12);
			b = coef_field(12);
			d[23:0] = {a[11:0], b[11:0]};
			load_register(bpc_pkg::REG_TEMP_COEF, d);
		end
		if ($urandom_range(0, 4) != 0) begin
			d = random_data();
			a = coef_field(20);
			b = coef_field(20);
			d[39:0] = {a, b};
			load_register(bpc_pkg::REG_PRES_OFFS, d);
		end
		if ($urandom_range(0, 4) != 0) begin
			d = random_data();
			a = coef_field(16);
			b = coef_field(16);
			d[31:0] = {a[15:0], b[15:0]};
			load_register(bpc_pkg::REG_CROSS, d);
		end
		if ($urandom_range(0, 4) != 0) begin
			d = random_data();
			a = coef_field(16);
			b = coef_field(16);
			c = coef_field(16);
			d[47:0] = {a[15:0], b[15:0], c[15:0]};
			load_register(bpc_pkg::REG_HIGHER, d);
		end
		if ($urandom_range(0, 3) != 0) begin
			load_register(bpc_pkg::REG_PRES_OSR, random_data());
		end
		if ($urandom_range(0, 3) != 0) begin
			load_register(bpc_pkg::REG_TEMP_OSR, random_data());
		end
		if ($urandom_range(0, 3) == 0) begin
			load_register($urandom_range(0, 1) ? SPARE_INDEX_LO : SPARE_INDEX_HI, random_data());
		end
	endtask

	initial begin
		int phase;
		int burst;
		phase = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer_sample(RAW_MAX, RAW_MIN);
		offer_sample(bpc_pkg::raw_t'(12345), bpc_pkg::raw_t'(-54321));
		settle();

		load_all({12'h7FF, 12'h7FF}, {20'h7FFFF, 20'h7FFFF}, {16'h7FFF, 16'h7FFF},
			{3{16'h7FFF}}, OSR_16X, OSR_16X);
		offer_extremes();
		settle();

		load_all({12'h800, 12'h800}, {20'h80000, 20'h80000}, {16'h8000, 16'h8000},
			{3{16'h8000}}, OSR_16X, OSR_8X);
		offer_extremes();
		settle();

		load_all('1, '1, '1, '1, OSR_128X, OSR_128X);
		offer_extremes();
		settle();

		load_all({12'd200, 12'(-260)}, {20'd80000, 20'(-50000)}, {16'(-3000), 16'd1200},
			{16'(-9000), 16'd100, 16'(-1000)}, OSR_16X, OSR_1X);
		repeat (6) begin
			offer_sample(bpc_pkg::raw_t'($urandom_range(0, 2000000) - 1000000),
				bpc_pkg::raw_t'($urandom_range(0, 2000000) - 1000000));
		end

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			configure_random();
			burst = $urandom_range(15, 60);
			tx_idles = ($urandom_range(0, 3) != 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == LONG_HOLD_PHASE) begin
				long_hold = 1'b1;
				tx_idles = 1'b0;
				burst = 80;
			end
			if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
				tx_idles = 1'b0;
				rx_quiet = 1'b1;
			end
			if (burst > ITEM_TARGET - items_sent) begin
				burst = ITEM_TARGET - items_sent;
			end
			repeat (burst) begin
				if (tx_idles && $urandom_range(0, 5) == 0) begin
					sender_gap($urandom_range(1, 19));
				end
				offer_sample(pick_raw(), pick_raw());
			end
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_barometer_pressure_compensation_unit: clean");
		end else begin
			$display("tb_barometer_pressure_compensation_unit: errors");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_cfg.sv
hw/rtl/bpc_scale.sv
hw/rtl/bpc_poly.sv
hw/rtl/bpc_out.sv
hw/rtl/barometer_pressure_compensation_unit.sv
hw/rtl/bpc_checker.sv
tb/bpc_result_checker.sv
tb/tb_barometer_pressure_compensation_unit.sv
